// File: rtl/least_loaded_group_instance_picker_assert.svh
// Assertion macros for the least-loaded group instance picker.
`ifndef LEAST_LOADED_GROUP_INSTANCE_PICKER_ASSERT_SVH
`define LEAST_LOADED_GROUP_INSTANCE_PICKER_ASSERT_SVH
`define LLGP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("llgp assertion failed");
`define LLGP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("llgp assertion failed");
`endif

// File: rtl/llgp_pkg.sv
// Package with commands, status codes and field widths of the picker.
package llgp_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_SET = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;
  localparam int MaxPicks = 16;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  context_id;
    logic [2:0]  group_num;
    logic [15:0] instance_tag;
    logic [3:0]  slot;
    logic [4:0]  want_count;
    logic        new_running;
  } llgp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        selected;
    logic [3:0]  picked_slot;
    logic [15:0] picked_tag;
    logic [4:0]  running_count;
    logic [4:0]  slots_in_use;
    logic        last;
  } llgp_out_t;
endpackage

// File: rtl/llgp_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
interface llgp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/least_loaded_group_instance_picker.sv
// Top level of the least-loaded group instance picker.
//
// Channel | Dir | Payload
// in      | in  | llgp_in_t: command, context_id, group_num, instance_tag, slot, ...
// out     | out | llgp_out_t: status, selected, picked_slot, picked_tag, running_count, ...
//
// Add and set register their result when the item is taken.
// A query or an acquire check scans the filled slots of the slot memory once, then decides.
// Each pick scans for an idle slot with the context, then if none for the lowest idle
// slot of the least-loaded group.
// A new item is taken once the last result has left; a stalled result holds the next pick.
// A synchronous reset clears the running flags and the fill count.
module least_loaded_group_instance_picker
  import llgp_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_GROUPS = 8
) (
  input logic clk,
  input logic rst_n,
  llgp_if.sink in_ch,
  llgp_if.source out_ch
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT = 3'd1;
  localparam logic [2:0] S_AFF = 3'd2;
  localparam logic [2:0] S_FB = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [7:0]  mem_ctx [NUM_SLOTS];
  logic [GW-1:0] mem_grp [NUM_SLOTS];
  logic [15:0] mem_tag [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] run_r;
  logic [CW-1:0] fill_r;

  logic [2:0] state_r;
  llgp_in_t cmd_r;
  llgp_out_t res_r;
  llgp_out_t start_res;
  logic out_v_r;
  logic [SW:0] idx_r;
  logic rd_v_r;
  logic [SW-1:0] rd_idx_r;
  logic [7:0] rd_ctx_r;
  logic [GW-1:0] rd_grp_r;
  logic [15:0] rd_tag_r;
  logic [CW-1:0] run_cnt_r [NUM_GROUPS];
  logic [CW-1:0] idle_cnt_r [NUM_GROUPS];
  logic [CW-1:0] idle_tot_r;
  logic [4:0] picks_r;
  logic [GW-1:0] best_g_r;
  logic [CW-1:0] best_c_r;
  logic found_r;
  logic [SW-1:0] found_s_r;
  logic [15:0] found_t_r;
  logic [GW-1:0] found_g_r;

  function automatic logic [4:0] sat(input logic [CW-1:0] v);
    return (CW > 5 && v > CW'(31)) ? 5'd31 : 5'(v);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = res_r;

  wire in_fire = in_ch.valid && in_ch.ready;
  wire out_fire = out_v_r && out_ch.ready;
  wire scanning = (state_r == S_CNT) || (state_r == S_AFF) || (state_r == S_FB);
  wire scan_end = (idx_r >= (SW+1)'(fill_r)) || (idx_r == (SW+1)'(NUM_SLOTS));
  wire rd_run = run_r[rd_idx_r];

  always_comb begin
    start_res = '0;
    start_res.last = 1'b1;
    start_res.slots_in_use = sat(fill_r);
    case (in_ch.data.command)
      CMD_ADD: begin
        if (fill_r >= CW'(NUM_SLOTS)) start_res.status = ST_FULL;
        else if (32'(in_ch.data.group_num) >= NUM_GROUPS) start_res.status = ST_BAD;
        else begin
          start_res.slots_in_use = sat(fill_r + 1'b1);
          start_res.selected = 1'b1;
          start_res.picked_slot = 4'(fill_r);
          start_res.picked_tag = in_ch.data.instance_tag;
        end
      end
      CMD_SET: begin
        if (32'(in_ch.data.slot) >= 32'(fill_r)) start_res.status = ST_BAD;
      end
      CMD_QUERY: begin
        if (32'(in_ch.data.group_num) >= NUM_GROUPS) start_res.status = ST_BAD;
      end
      default: begin
        if (in_ch.data.want_count > 5'(MaxPicks)) start_res.status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.data.command == CMD_ADD && fill_r < CW'(NUM_SLOTS) &&
        32'(in_ch.data.group_num) < NUM_GROUPS) begin
      mem_ctx[fill_r[SW-1:0]] <= in_ch.data.context_id;
      mem_grp[fill_r[SW-1:0]] <= GW'(in_ch.data.group_num);
      mem_tag[fill_r[SW-1:0]] <= in_ch.data.instance_tag;
    end
    rd_ctx_r <= mem_ctx[idx_r[SW-1:0]];
    rd_grp_r <= mem_grp[idx_r[SW-1:0]];
    rd_tag_r <= mem_tag[idx_r[SW-1:0]];
    rd_idx_r <= idx_r[SW-1:0];
  end

  // Least-loaded eligible group over the count tables, ties to the lowest id.
  logic [GW-1:0] lg;
  logic [CW-1:0] lc;
  logic lok;
  always_comb begin
    lg = '0;
    lc = '0;
    lok = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (idle_cnt_r[g] != '0 && (!lok || run_cnt_r[g] < lc)) begin
        lok = 1'b1;
        lg = GW'(g);
        lc = run_cnt_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      run_r <= '0;
      fill_r <= '0;
      rd_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (out_fire) out_v_r <= 1'b0;
      rd_v_r <= scanning && !scan_end;
      if (scanning && !scan_end) idx_r <= idx_r + 1'b1;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_ch.data;
            res_r <= start_res;
            idx_r <= '0;
            picks_r <= '0;
            idle_tot_r <= '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
              run_cnt_r[g] <= '0;
              idle_cnt_r[g] <= '0;
            end
            case (in_ch.data.command)
              CMD_ADD: begin
                if (start_res.status == ST_OK) begin
                  run_r[fill_r[SW-1:0]] <= 1'b0;
                  fill_r <= fill_r + 1'b1;
                end
                out_v_r <= 1'b1;
              end
              CMD_SET: begin
                if (start_res.status == ST_OK)
                  run_r[SW'(in_ch.data.slot)] <= in_ch.data.new_running;
                out_v_r <= 1'b1;
              end
              default: begin
                if (start_res.status != ST_OK) out_v_r <= 1'b1;
                else state_r <= S_CNT;
              end
            endcase
          end
        end
        S_CNT: begin
          if (rd_v_r) begin
            if (rd_run) run_cnt_r[rd_grp_r] <= run_cnt_r[rd_grp_r] + 1'b1;
            else begin
              idle_cnt_r[rd_grp_r] <= idle_cnt_r[rd_grp_r] + 1'b1;
              idle_tot_r <= idle_tot_r + 1'b1;
            end
          end else if (scan_end) begin
            idx_r <= '0;
            if (cmd_r.command == CMD_QUERY) begin
              res_r.running_count <= sat(run_cnt_r[GW'(cmd_r.group_num)]);
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (32'(idle_tot_r) < 32'(cmd_r.want_count)) begin
              res_r.status <= ST_BUSY;
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (cmd_r.want_count == '0) begin
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              best_g_r <= lg;
              best_c_r <= lc;
              found_r <= 1'b0;
              state_r <= S_AFF;
            end
          end
        end
        S_AFF: begin
          // The lowest least-loaded group with an idle slot of the context wins.
          if (rd_v_r) begin
            if (!rd_run && rd_ctx_r == cmd_r.context_id &&
                rd_grp_r >= best_g_r && idle_cnt_r[rd_grp_r] != '0 &&
                run_cnt_r[rd_grp_r] == best_c_r && (!found_r || rd_grp_r < found_g_r)) begin
              found_r <= 1'b1;
              found_s_r <= rd_idx_r;
              found_t_r <= rd_tag_r;
              found_g_r <= rd_grp_r;
            end
          end else if (scan_end) begin
            idx_r <= '0;
            state_r <= found_r ? S_OUT : S_FB;
          end
        end
        S_FB: begin
          if (rd_v_r) begin
            if (!found_r && !rd_run && rd_grp_r == best_g_r) begin
              found_r <= 1'b1;
              found_s_r <= rd_idx_r;
              found_t_r <= rd_tag_r;
              found_g_r <= rd_grp_r;
            end
          end else if (scan_end) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v_r) begin
            run_r[found_s_r] <= 1'b1;
            run_cnt_r[found_g_r] <= run_cnt_r[found_g_r] + 1'b1;
            idle_cnt_r[found_g_r] <= idle_cnt_r[found_g_r] - 1'b1;
            res_r.status <= ST_OK;
            res_r.selected <= 1'b1;
            res_r.picked_slot <= 4'(found_s_r);
            res_r.picked_tag <= found_t_r;
            res_r.last <= (picks_r + 1'b1 == cmd_r.want_count);
            picks_r <= picks_r + 1'b1;
            out_v_r <= 1'b1;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (picks_r == cmd_r.want_count) state_r <= S_IDLE;
          else if (lok) begin
            best_g_r <= lg;
            best_c_r <= lc;
            found_r <= 1'b0;
            idx_r <= '0;
            state_r <= S_AFF;
          end else state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "least_loaded_group_instance_picker_assert.svh"
  `LLGP_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_r == S_IDLE)
  `LLGP_ASSERT_NXT(a_fill_mono, clk, rst_n, 1'b1, fill_r >= $past(fill_r))
  `LLGP_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_r <= CW'(NUM_SLOTS))
  `LLGP_ASSERT_IMP(a_pick_found, clk, rst_n, state_r == S_OUT, found_r)
endmodule

// File: verif/testbench.sv
// Self-checking testbench for the least-loaded group instance picker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import llgp_pkg::*;

  localparam int NSLOT = 16;
  localparam int NGRP = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;

  llgp_if #(.payload_t(llgp_in_t)) in_if ();
  llgp_if #(.payload_t(llgp_out_t)) out_if ();

  least_loaded_group_instance_picker dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if.sink),
    .out_ch(out_if.source)
  );

  // Shadow copy of the worker table.
  logic [7:0]  shadow_ctx [NSLOT];
  logic [2:0]  shadow_grp [NSLOT];
  logic [15:0] shadow_tag [NSLOT];
  logic        shadow_run [NSLOT];
  int          shadow_filled;

  llgp_out_t pending_results[$];
  int mismatch_count;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_count;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic llgp_out_t make_result(logic [1:0] status, logic sel, int slot_idx,
                                            logic [15:0] tag, int count, logic is_last);
    llgp_out_t r;
    r.status = status;
    r.selected = sel;
    r.picked_slot = sel ? slot_idx[3:0] : 4'd0;
    r.picked_tag = sel ? tag : 16'd0;
    r.running_count = count[4:0];
    r.slots_in_use = shadow_filled[4:0];
    r.last = is_last;
    return r;
  endfunction

  function automatic void add_expected(llgp_out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int group_load(int g, logic want_running);
    int n;
    n = 0;
    for (int i = 0; i < shadow_filled; i++)
      if (shadow_grp[i] == g && shadow_run[i] == want_running) n++;
    return n;
  endfunction

  function automatic int idle_slots();
    int n;
    n = 0;
    for (int i = 0; i < shadow_filled; i++)
      if (!shadow_run[i]) n++;
    return n;
  endfunction

  function automatic int choose_slot(logic [7:0] ctx);
    int best;
    int first;
    best = NSLOT + 1;
    first = NGRP;
    for (int g = 0; g < NGRP; g++)
      if (group_load(g, 1'b0) > 0 && group_load(g, 1'b1) < best) begin
        best = group_load(g, 1'b1);
        first = g;
      end
    if (first == NGRP) return NSLOT;
    for (int g = first; g < NGRP; g++)
      if (group_load(g, 1'b0) > 0 && group_load(g, 1'b1) == best)
        for (int i = 0; i < shadow_filled; i++)
          if (shadow_grp[i] == g && !shadow_run[i] && shadow_ctx[i] == ctx) return i;
    for (int i = 0; i < shadow_filled; i++)
      if (shadow_grp[i] == first && !shadow_run[i]) return i;
    return NSLOT;
  endfunction

  task automatic predict_results(llgp_in_t it);
    int s;
    case (it.command)
      CMD_ADD: begin
        if (shadow_filled >= NSLOT) begin
          add_expected(make_result(ST_FULL, 1'b0, 0, 16'd0, 0, 1'b1));
        end else begin
          s = shadow_filled;
          shadow_ctx[s] = it.context_id;
          shadow_grp[s] = it.group_num;
          shadow_tag[s] = it.instance_tag;
          shadow_run[s] = 1'b0;
          shadow_filled++;
          add_expected(make_result(ST_OK, 1'b1, s, it.instance_tag, 0, 1'b1));
        end
      end
      CMD_SET: begin
        if (it.slot >= shadow_filled) begin
          add_expected(make_result(ST_BAD, 1'b0, 0, 16'd0, 0, 1'b1));
        end else begin
          shadow_run[it.slot] = it.new_running;
          add_expected(make_result(ST_OK, 1'b0, 0, 16'd0, 0, 1'b1));
        end
      end
      CMD_QUERY: begin
        add_expected(make_result(ST_OK, 1'b0, 0, 16'd0,
                                 group_load(it.group_num, 1'b1), 1'b1));
      end
      default: begin
        if (it.want_count > MaxPicks) begin
          add_expected(make_result(ST_BAD, 1'b0, 0, 16'd0, 0, 1'b1));
        end else if (idle_slots() < it.want_count) begin
          add_expected(make_result(ST_BUSY, 1'b0, 0, 16'd0, 0, 1'b1));
        end else if (it.want_count == 0) begin
          add_expected(make_result(ST_OK, 1'b0, 0, 16'd0, 0, 1'b1));
        end else begin
          for (int k = 0; k < it.want_count; k++) begin
            s = choose_slot(it.context_id);
            shadow_run[s] = 1'b1;
            add_expected(make_result(ST_OK, 1'b1, s, shadow_tag[s], 0,
                                     k + 1 == it.want_count));
          end
        end
      end
    endcase
  endtask

  task automatic send_item(llgp_in_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_results(it);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic llgp_in_t item_of(logic [1:0] cmd, logic [7:0] ctx, logic [2:0] grp,
                                       logic [15:0] tag, logic [3:0] slot_idx,
                                       logic [4:0] want, logic flag);
    llgp_in_t it;
    it.command = cmd;
    it.context_id = ctx;
    it.group_num = grp;
    it.instance_tag = tag;
    it.slot = slot_idx;
    it.want_count = want;
    it.new_running = flag;
    return it;
  endfunction

  function automatic llgp_in_t random_item();
    llgp_in_t it;
    int idle;
    int roll;
    it = item_of(2'($urandom()), 8'($urandom()), 3'($urandom()), 16'($urandom()),
                 4'($urandom()), 5'($urandom()), 1'($urandom()));
    roll = $urandom_range(99);
    idle = idle_slots();
    if (roll < 5) return it;
    if (roll < 12) begin
      it.command = CMD_ADD;
    end else if (roll < 55) begin
      it.command = CMD_ACQUIRE;
      it.context_id = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(3));
      if ($urandom_range(9) == 0) it.want_count = 5'($urandom_range(31));
      else it.want_count = 5'($urandom_range(idle > 0 ? 1 : 0, idle < 4 ? idle + 1 : 4));
    end else if (roll < 85) begin
      it.command = CMD_SET;
      it.new_running = $urandom_range(9) < 3;
    end else begin
      it.command = CMD_QUERY;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_if.data);
      end else if (pending_results[0] !== out_if.data) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected %p, actual %p", pending_results[0], out_if.data);
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  task automatic test_directed();
    send_item(item_of(CMD_QUERY, 8'd0, 3'd7, 16'd0, 4'd0, 5'd0, 1'b0));
    send_item(item_of(CMD_SET, 8'd0, 3'd0, 16'd0, 4'd0, 5'd0, 1'b1));
    send_item(item_of(CMD_ACQUIRE, 8'd0, 3'd0, 16'd0, 4'd0, 5'd0, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd0, 3'd0, 16'd0, 4'd0, 5'd1, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd0, 3'd0, 16'd0, 4'd0, 5'd17, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd0, 3'd0, 16'd0, 4'd0, 5'd31, 1'b0));
    for (int i = 0; i < NSLOT; i++)
      send_item(item_of(CMD_ADD, i == 0 ? 8'd255 : 8'(i % 3), 3'(i * 5),
                        i == 0 ? 16'hFFFF : 16'($urandom()), 4'd0, 5'd0, 1'b0));
    send_item(item_of(CMD_ADD, 8'd1, 3'd2, 16'h1234, 4'd0, 5'd0, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd255, 3'd0, 16'd0, 4'd15, 5'd16, 1'b1));
    send_item(item_of(CMD_QUERY, 8'd0, 3'd7, 16'd0, 4'd0, 5'd0, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd0, 3'd0, 16'd0, 4'd0, 5'd1, 1'b0));
    for (int i = 0; i < NSLOT; i++)
      send_item(item_of(CMD_SET, 8'd0, 3'd0, 16'd0, 4'(i), 5'd0, 1'b0));
    send_item(item_of(CMD_ACQUIRE, 8'd2, 3'd0, 16'd0, 4'd0, 5'd16, 1'b0));
    wait_drained();
  endtask

  task automatic test_random(int idle_pct, int stall, int count);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 20; i++) send_item(random_item());
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    shadow_filled = 0;
    for (int i = 0; i < NSLOT; i++) shadow_run[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 120);
    test_random(81, 0, 120);
    test_random(0, 81, 120);
    test_random(30, 30, 120);
    test_backpressure();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/llgp_pkg.sv
rtl/llgp_if.sv
rtl/least_loaded_group_instance_picker.sv
verif/testbench.sv
